// ===== hw/rtl/midpoint_ellipse_span_fill_assert.svh =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_span_fill_assert.svh
// Assertion macros shared by the span fill checker.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_SPAN_FILL_ASSERT_SVH
`define MIDPOINT_ELLIPSE_SPAN_FILL_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MESF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("span fill check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is held.
`define MESF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("span fill check failed: next-cycle rule");

`endif

// ===== hw/rtl/mesf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesf_pkg
// Types and codes shared by the midpoint ellipse span fill modules.
// ----------------------------------------------------------------------------
package mesf_pkg;

    // Input item kinds
    localparam logic KIND_LOAD = 1'b0;

    // Span slots produced by one step, in emission order
    localparam int SLOT_W = 3;
    localparam int NUM_SLOTS = 6;
    localparam logic [SLOT_W-1:0] SLOT_DOT_LO = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_DOT_HI = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_ROW_LO = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_ROW_HI = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_END_LO = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_END_HI = 3'd5;

    // Region the ellipse walk is in
    typedef enum logic [1:0] {
        STG_IDLE,
        STG_ONE,
        STG_TWO,
        STG_DONE
    } stage_t;

    // Sequencer states
    typedef enum logic [3:0] {
        C_IDLE,
        C_LD_WH,
        C_LD_SQ,
        C_LD_H2,
        C_LD_W2,
        C_CHK_X,
        C_CHK_Y,
        C_CHK_CMP,
        C_ST_TX,
        C_ST_TXSQ,
        C_ST_TY,
        C_ST_TYSQ,
        C_ST_CMP,
        C_EMIT
    } ctl_t;

    // Selects which span the formatter builds
    typedef struct packed {
        logic              two;
        logic [SLOT_W-1:0] slot;
    } slot_ctl_t;

endpackage

// ===== hw/rtl/mesf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesf_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module mesf_mul #(
    parameter int WIDTH = 22
) (
    input  logic               clk,
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    output logic [2*WIDTH-1:0] prod
);

    logic [2*WIDTH-1:0] prod_reg;

    // Register the product
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/mesf_span.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesf_span
// Builds the rectangle of one span slot from the walk registers.
// ----------------------------------------------------------------------------
module mesf_span
    import mesf_pkg::*;
#(
    parameter int SIZE_BITS  = 10,
    parameter int COORD_BITS = 16
) (
    input  slot_ctl_t                     slot_ctl,
    input  logic signed [COORD_BITS-1:0]  cx,
    input  logic signed [COORD_BITS-1:0]  cy,
    input  logic        [SIZE_BITS:0]     x,
    input  logic        [SIZE_BITS-1:0]   y,
    input  logic        [SIZE_BITS:0]     px,
    input  logic        [SIZE_BITS-1:0]   py,
    input  logic        [SIZE_BITS:0]     opx,
    input  logic        [SIZE_BITS-1:0]   opy,
    output logic signed [COORD_BITS:0]    sx,
    output logic signed [COORD_BITS:0]    sy,
    output logic        [SIZE_BITS:0]     sw,
    output logic        [SIZE_BITS:0]     sh
);

    localparam int AW = ((COORD_BITS > SIZE_BITS + 1) ? COORD_BITS : SIZE_BITS + 1) + 2;

    logic signed [AW-1:0] cxe, cye, xe, ye, pxe, pye, opxe, opye;
    logic signed [AW-1:0] fx, fy, fw, fh;

    // Widen everything to one signed working width
    assign cxe  = AW'(cx);
    assign cye  = AW'(cy);
    assign xe   = AW'(x);
    assign ye   = AW'(y);
    assign pxe  = AW'(px);
    assign pye  = AW'(py);
    assign opxe = AW'(opx);
    assign opye = AW'(opy);

    // Pick the corner and size of the selected span
    always_comb
    begin
        fx = '0;
        fy = '0;
        fw = '0;
        fh = '0;
        unique case (slot_ctl.slot)
            SLOT_DOT_LO:
            begin
                fx = cxe;
                fy = cye + opye - AW'(1);
                fw = AW'(1);
                fh = AW'(1);
            end
            SLOT_DOT_HI:
            begin
                fx = cxe;
                fy = cye - opye;
                fw = AW'(1);
                fh = AW'(1);
            end
            SLOT_ROW_LO:
            begin
                if (slot_ctl.two)
                begin
                    fx = cxe - opxe;
                    fy = cye - opye;
                    fw = AW'(2) * opxe + AW'(1);
                    fh = opye - ye;
                end
                else
                begin
                    fx = cxe - xe + AW'(1);
                    fy = cye - opye;
                    fw = AW'(2) * xe - AW'(1);
                    fh = AW'(1);
                end
            end
            SLOT_ROW_HI:
            begin
                if (slot_ctl.two)
                begin
                    fx = cxe - opxe;
                    fy = cye + ye + AW'(1);
                    fw = AW'(2) * opxe + AW'(1);
                    fh = opye - ye;
                end
                else
                begin
                    fx = cxe - xe + AW'(1);
                    fy = cye + opye;
                    fw = AW'(2) * xe - AW'(1);
                    fh = AW'(1);
                end
            end
            SLOT_END_LO:
            begin
                if (slot_ctl.two)
                begin
                    fx = cxe - pxe;
                    fy = cye - pye;
                    fw = AW'(2) * xe + AW'(1);
                    fh = pye - ye + AW'(1);
                end
                else
                begin
                    fx = cxe - xe;
                    fy = cye - ye;
                    fw = AW'(2) * xe + AW'(1);
                    fh = AW'(1);
                end
            end
            SLOT_END_HI:
            begin
                if (slot_ctl.two)
                begin
                    fx = cxe - pxe;
                    fy = cye + ye;
                    fw = AW'(2) * xe + AW'(1);
                    fh = pye - ye + AW'(1);
                end
                else
                begin
                    fx = cxe - xe;
                    fy = cye + ye;
                    fw = AW'(2) * xe + AW'(1);
                    fh = AW'(1);
                end
            end
            default:
            begin
                fx = '0;
                fy = '0;
                fw = '0;
                fh = '0;
            end
        endcase
    end

    // Trim to port widths
    assign sx = fx[COORD_BITS:0];
    assign sy = fy[COORD_BITS:0];
    assign sw = fw[SIZE_BITS:0];
    assign sh = fh[SIZE_BITS:0];

endmodule

// ===== hw/rtl/midpoint_ellipse_span_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_span_fill
// Filled-ellipse span generator using the two-region midpoint walk.
// ----------------------------------------------------------------------------
// A load beat latches centre, size and colour, then runs C_LD_WH to C_CHK_CMP and
// produces no output. A step beat in region one runs C_ST_TX to C_ST_CMP, then
// C_CHK_X to C_CHK_CMP, in region two C_ST_TX to C_ST_CMP only; C_EMIT then walks
// the span slots up to the last one present, one output beat per span (one empty
// beat when the step makes none). A step on an idle or finished ellipse goes
// straight to a single empty beat. All squared terms run through one registered
// multiplier of 2*SIZE_BITS+2 bits per operand, one product per cycle, and that
// unit sets the step length. in_stall is high for the whole of an item's work;
// the output register lets the next item in while a beat waits to be taken.
// ----------------------------------------------------------------------------
module midpoint_ellipse_span_fill
    import mesf_pkg::*;
#(
    parameter int SIZE_BITS  = 10,
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         kind,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic        [SIZE_BITS-1:0]  ellipse_width,
    input  logic        [SIZE_BITS-1:0]  ellipse_height,
    input  logic        [31:0]           fill_color,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS:0]   span_x,
    output logic signed [COORD_BITS:0]   span_y,
    output logic        [SIZE_BITS:0]    span_width,
    output logic        [SIZE_BITS:0]    span_height,
    output logic        [31:0]           span_color,
    output logic                         span_valid,
    output logic                         last_of_step,
    output logic                         finished
);

    localparam int MW = 2 * SIZE_BITS + 2;
    localparam int PW = 2 * MW;
    localparam int WW = 4 * SIZE_BITS;
    localparam int QW = 2 * SIZE_BITS;
    localparam int XW = SIZE_BITS + 1;

    // Sequencer and walk state
    ctl_t                         ctl_reg, ctl_next;
    stage_t                       stage_reg, stage_next;
    logic                         loading_reg, loading_next;
    logic                         two_reg, two_next;
    logic [XW-1:0]                x_reg, x_next;
    logic [SIZE_BITS-1:0]         y_reg, y_next;
    logic [XW-1:0]                px_reg, px_next;
    logic [SIZE_BITS-1:0]         py_reg, py_next;
    logic [XW-1:0]                opx_reg, opx_next;
    logic [SIZE_BITS-1:0]         opy_reg, opy_next;
    logic [NUM_SLOTS-1:0]         en_reg, en_next;
    logic [SLOT_W-1:0]            cnt_reg, cnt_next;

    // Held ellipse and precomputed squares
    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic [SIZE_BITS-1:0]         w_reg, w_next;
    logic [SIZE_BITS-1:0]         h_reg, h_next;
    logic [31:0]                  color_reg, color_next;
    logic [WW-1:0]                whole_reg, whole_next;
    logic [QW-1:0]                h2_reg, h2_next;
    logic [QW-1:0]                w2_reg, w2_next;
    logic [PW-1:0]                acc_reg, acc_next;

    // Output register
    logic                         ov_reg, ov_next;
    logic signed [COORD_BITS:0]   ox_reg, ox_next;
    logic signed [COORD_BITS:0]   oy_reg, oy_next;
    logic [SIZE_BITS:0]           ow_reg, ow_next;
    logic [SIZE_BITS:0]           oh_reg, oh_next;
    logic [31:0]                  ocol_reg, ocol_next;
    logic                         osv_reg, osv_next;
    logic                         olast_reg, olast_next;
    logic                         ofin_reg, ofin_next;

    // Multiplier and formatter hookup
    logic [MW-1:0]                mul_a, mul_b;
    logic [PW-1:0]                prod;
    logic [XW:0]                  tx;
    logic [SIZE_BITS:0]           ty;
    logic [PW:0]                  sum;
    logic                         sum_ge_whole;
    logic                         sum_le_whole;
    logic                         holds;
    logic                         above;
    logic                         out_free;
    logic                         chg;
    logic                         rgo;
    logic [XW-1:0]                x_inc;
    slot_ctl_t                    span_ctl;
    logic signed [COORD_BITS:0]   sx;
    logic signed [COORD_BITS:0]   sy;
    logic [SIZE_BITS:0]           sw;
    logic [SIZE_BITS:0]           sh;

    mesf_mul #(
        .WIDTH (MW)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign span_ctl = '{two: two_reg, slot: cnt_reg};

    mesf_span #(
        .SIZE_BITS  (SIZE_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_span (
        .slot_ctl (span_ctl),
        .cx       (cx_reg),
        .cy       (cy_reg),
        .x        (x_reg),
        .y        (y_reg),
        .px       (px_reg),
        .py       (py_reg),
        .opx      (opx_reg),
        .opy      (opy_reg),
        .sx       (sx),
        .sy       (sy),
        .sw       (sw),
        .sh       (sh)
    );

    // Column and row terms: region one tests 2x and 2y-1, region two 2x+1 and 2y
    assign tx = {x_reg, two_reg};
    assign ty = {y_reg, 1'b0} - (SIZE_BITS + 1)'(!two_reg);

    // Route operands into the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctl_reg) inside
            C_LD_WH:
            begin
                mul_a = MW'(w_reg);
                mul_b = MW'(h_reg);
            end
            C_LD_SQ, C_ST_TXSQ, C_ST_TYSQ:
            begin
                mul_a = prod[MW-1:0];
                mul_b = prod[MW-1:0];
            end
            C_LD_H2:
            begin
                mul_a = MW'(h_reg);
                mul_b = MW'(h_reg);
            end
            C_LD_W2:
            begin
                mul_a = MW'(w_reg);
                mul_b = MW'(w_reg);
            end
            C_CHK_X:
            begin
                mul_a = MW'(h2_reg);
                mul_b = MW'(x_reg);
            end
            C_CHK_Y:
            begin
                mul_a = MW'(w2_reg);
                mul_b = MW'(y_reg);
            end
            C_ST_TX:
            begin
                mul_a = MW'(h_reg);
                mul_b = MW'(tx);
            end
            C_ST_TY:
            begin
                mul_a = MW'(w_reg);
                mul_b = MW'(ty);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Point tests against the scaled ellipse
    assign sum          = {1'b0, acc_reg} + {1'b0, prod};
    assign sum_ge_whole = sum >= (PW + 1)'(whole_reg);
    assign sum_le_whole = sum <= (PW + 1)'(whole_reg);
    assign holds        = acc_reg < prod;
    assign x_inc        = x_reg + 1'b1;
    assign out_free     = !ov_reg || !out_stall;

    // Look for a present slot after the current one
    always_comb
    begin
        above = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (en_reg[i] && (SLOT_W'(i) > cnt_reg))
            begin
                above = 1'b1;
            end
        end
    end

    // Region decisions reused by both comparison states
    assign chg = (ctl_reg == C_ST_CMP) ? (sum_le_whole ? px_reg != x_inc : px_reg != x_reg)
                                       : (y_reg != opy_reg);
    assign rgo = !holds;

    // Next state and datapath updates
    always_comb
    begin
        ctl_next     = ctl_reg;
        stage_next   = stage_reg;
        loading_next = loading_reg;
        two_next     = two_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        opx_next     = opx_reg;
        opy_next     = opy_reg;
        en_next      = en_reg;
        cnt_next     = cnt_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        color_next   = color_reg;
        whole_next   = whole_reg;
        h2_next      = h2_reg;
        w2_next      = w2_reg;
        acc_next     = acc_reg;
        ov_next      = ov_reg && out_stall;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        ow_next      = ow_reg;
        oh_next      = oh_reg;
        ocol_next    = ocol_reg;
        osv_next     = osv_reg;
        olast_next   = olast_reg;
        ofin_next    = ofin_reg;

        unique case (ctl_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    cnt_next = '0;
                    opx_next = px_reg;
                    opy_next = py_reg;
                    if (kind == KIND_LOAD)
                    begin
                        // Latch the ellipse and start at the top row
                        cx_next      = center_x;
                        cy_next      = center_y;
                        w_next       = ellipse_width;
                        h_next       = ellipse_height;
                        color_next   = fill_color;
                        x_next       = '0;
                        y_next       = ellipse_height >> 1;
                        px_next      = XW'(1);
                        py_next      = ellipse_height >> 1;
                        loading_next = 1'b1;
                        ctl_next     = C_LD_WH;
                    end
                    else
                    begin
                        loading_next = 1'b0;
                        if (stage_reg == STG_ONE)
                        begin
                            x_next   = x_inc;
                            two_next = 1'b0;
                            ctl_next = C_ST_TX;
                        end
                        else if (stage_reg == STG_TWO)
                        begin
                            y_next   = y_reg - 1'b1;
                            two_next = 1'b1;
                            ctl_next = C_ST_TX;
                        end
                        else
                        begin
                            en_next  = '0;
                            ctl_next = C_EMIT;
                        end
                    end
                end
            end
            C_LD_WH:
            begin
                ctl_next = C_LD_SQ;
            end
            C_LD_SQ:
            begin
                ctl_next = C_LD_H2;
            end
            C_LD_H2:
            begin
                whole_next = prod[WW-1:0];
                ctl_next   = C_LD_W2;
            end
            C_LD_W2:
            begin
                h2_next  = prod[QW-1:0];
                ctl_next = C_CHK_X;
            end
            C_CHK_X:
            begin
                if (loading_reg)
                begin
                    w2_next = prod[QW-1:0];
                end
                ctl_next = C_CHK_Y;
            end
            C_CHK_Y:
            begin
                acc_next = prod;
                ctl_next = C_CHK_CMP;
            end
            C_CHK_CMP:
            begin
                if (loading_reg)
                begin
                    // Pick the starting region
                    if (holds)
                    begin
                        stage_next = STG_ONE;
                    end
                    else
                    begin
                        px_next    = x_reg;
                        py_next    = y_reg;
                        stage_next = (y_reg != '0) ? STG_TWO : STG_DONE;
                    end
                    ctl_next = C_IDLE;
                end
                else
                begin
                    // Region one: mark dot, row and region-end spans
                    en_next = {rgo, rgo, chg, chg,
                               (x_reg == XW'(1)) && chg, (x_reg == XW'(1)) && chg};
                    py_next = y_reg;
                    if (chg || rgo)
                    begin
                        px_next = x_reg;
                    end
                    if (rgo)
                    begin
                        stage_next = (y_reg != '0) ? STG_TWO : STG_DONE;
                    end
                    ctl_next = C_EMIT;
                end
            end
            C_ST_TX:
            begin
                ctl_next = C_ST_TXSQ;
            end
            C_ST_TXSQ:
            begin
                ctl_next = C_ST_TY;
            end
            C_ST_TY:
            begin
                acc_next = prod;
                ctl_next = C_ST_TYSQ;
            end
            C_ST_TYSQ:
            begin
                ctl_next = C_ST_CMP;
            end
            C_ST_CMP:
            begin
                if (!two_reg)
                begin
                    // Region one: move up a row when on or outside the edge
                    if (sum_ge_whole)
                    begin
                        y_next = y_reg - 1'b1;
                    end
                    ctl_next = C_CHK_X;
                end
                else
                begin
                    // Region two: move out a column when on or inside the edge
                    if (sum_le_whole)
                    begin
                        x_next = x_inc;
                    end
                    en_next = {y_reg == '0, y_reg == '0, chg, chg, 1'b0, 1'b0};
                    if (chg)
                    begin
                        px_next = sum_le_whole ? x_inc : x_reg;
                        py_next = y_reg;
                    end
                    if (y_reg == '0)
                    begin
                        stage_next = STG_DONE;
                    end
                    ctl_next = C_EMIT;
                end
            end
            C_EMIT:
            begin
                if ((en_reg != '0) && !en_reg[cnt_reg])
                begin
                    // Skip an absent slot
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    ov_next   = 1'b1;
                    ocol_next = color_reg;
                    ofin_next = !(stage_reg == STG_ONE || stage_reg == STG_TWO);
                    if (en_reg == '0)
                    begin
                        // Empty beat
                        ox_next    = '0;
                        oy_next    = '0;
                        ow_next    = '0;
                        oh_next    = '0;
                        osv_next   = 1'b0;
                        olast_next = 1'b1;
                        ctl_next   = C_IDLE;
                    end
                    else
                    begin
                        ox_next    = sx;
                        oy_next    = sy;
                        ow_next    = sw;
                        oh_next    = sh;
                        osv_next   = 1'b1;
                        olast_next = !above;
                        cnt_next   = cnt_reg + 1'b1;
                        ctl_next   = above ? C_EMIT : C_IDLE;
                    end
                end
            end
            default:
            begin
                ctl_next = C_IDLE;
            end
        endcase
    end

    // Control and walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg     <= C_IDLE;
            stage_reg   <= STG_IDLE;
            loading_reg <= 1'b0;
            two_reg     <= 1'b0;
            x_reg       <= '0;
            y_reg       <= '0;
            px_reg      <= '0;
            py_reg      <= '0;
            en_reg      <= '0;
            cnt_reg     <= '0;
            color_reg   <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            ctl_reg     <= ctl_next;
            stage_reg   <= stage_next;
            loading_reg <= loading_next;
            two_reg     <= two_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            px_reg      <= px_next;
            py_reg      <= py_next;
            en_reg      <= en_next;
            cnt_reg     <= cnt_next;
            color_reg   <= color_next;
            ov_reg      <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        opx_reg   <= opx_next;
        opy_reg   <= opy_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        whole_reg <= whole_next;
        h2_reg    <= h2_next;
        w2_reg    <= w2_next;
        acc_reg   <= acc_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        ow_reg    <= ow_next;
        oh_reg    <= oh_next;
        ocol_reg  <= ocol_next;
        osv_reg   <= osv_next;
        olast_reg <= olast_next;
        ofin_reg  <= ofin_next;
    end

    // Ports
    assign in_stall     = (ctl_reg != C_IDLE);
    assign out_valid    = ov_reg;
    assign span_x       = ox_reg;
    assign span_y       = oy_reg;
    assign span_width   = ow_reg;
    assign span_height  = oh_reg;
    assign span_color   = ocol_reg;
    assign span_valid   = osv_reg;
    assign last_of_step = olast_reg;
    assign finished     = ofin_reg;

endmodule

// ===== hw/rtl/mesf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesf_checker
// Port-level checks for the midpoint ellipse span fill, bound to the top.
// ----------------------------------------------------------------------------
`include "midpoint_ellipse_span_fill_assert.svh"

module mesf_checker #(
    parameter int SIZE_BITS  = 10,
    parameter int COORD_BITS = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [COORD_BITS:0]   span_x,
    input logic signed [COORD_BITS:0]   span_y,
    input logic        [SIZE_BITS:0]    span_width,
    input logic        [SIZE_BITS:0]    span_height,
    input logic        [31:0]           span_color,
    input logic                         span_valid,
    input logic                         last_of_step,
    input logic                         finished
);

    localparam int BEAT_W = 2 * (COORD_BITS + 1) + 2 * (SIZE_BITS + 1) + 35;

    logic [BEAT_W-1:0] out_beat;
    logic              out_held;
    logic              empty_shape;
    logic              real_shape;

    // Gather the output beat and the shape rules
    assign out_beat    = {span_x, span_y, span_width, span_height, span_color,
                          span_valid, last_of_step, finished};
    assign out_held    = out_valid && out_stall;
    assign empty_shape = last_of_step && (span_width == '0) && (span_height == '0);
    assign real_shape  = span_width[0] && (span_height != '0);

    // Hold a stalled beat
    `MESF_ASSERT_NXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_beat))

    // Every accepted item makes the block busy in the cycle after it is accepted
    `MESF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // An empty beat is zero-sized and closes its step
    `MESF_ASSERT_IMP(a_empty_beat, clk, rst_n, out_valid && !span_valid, empty_shape)

    // A real span is an odd width and at least one row tall
    `MESF_ASSERT_IMP(a_span_shape, clk, rst_n, out_valid && span_valid, real_shape)

endmodule

bind midpoint_ellipse_span_fill mesf_checker #(
    .SIZE_BITS  (SIZE_BITS),
    .COORD_BITS (COORD_BITS)
) u_mesf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .span_x       (span_x),
    .span_y       (span_y),
    .span_width   (span_width),
    .span_height  (span_height),
    .span_color   (span_color),
    .span_valid   (span_valid),
    .last_of_step (last_of_step),
    .finished     (finished)
);

// ===== tb/midpoint_ellipse_span_fill_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesf_span_checker
// Watches both channels of the ellipse span generator, predicts every span
// beat from the accepted input beats and compares the output beats in order.
// ----------------------------------------------------------------------------
module mesf_span_checker
    import mesf_pkg::*;
#(
    parameter int SIZE_BITS  = 10,
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         kind,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic        [SIZE_BITS-1:0]  ellipse_width,
    input  logic        [SIZE_BITS-1:0]  ellipse_height,
    input  logic        [31:0]           fill_color,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [COORD_BITS:0]   span_x,
    input  logic signed [COORD_BITS:0]   span_y,
    input  logic        [SIZE_BITS:0]    span_width,
    input  logic        [SIZE_BITS:0]    span_height,
    input  logic        [31:0]           span_color,
    input  logic                         span_valid,
    input  logic                         last_of_step,
    input  logic                         finished,
    input  logic                         end_of_test,
    output int                           err_count,
    output int                           pending
);

    typedef struct {
        logic signed [COORD_BITS:0] x;
        logic signed [COORD_BITS:0] y;
        logic        [SIZE_BITS:0]  w;
        logic        [SIZE_BITS:0]  h;
        logic        [31:0]         color;
        logic                       vld;
        logic                       last;
        logic                       fin;
    } span_beat_t;

    // Walk state of the ellipse as the block should hold it
    stage_t               walk_stage;
    int                   walk_x, walk_y, last_x, last_y;
    int                   org_x, org_y;
    logic [SIZE_BITS-1:0] dia_w, dia_h;
    logic [31:0]          tag;
    logic                 leftover_done;

    span_beat_t due_spans[$];

    initial err_count = 0;
    initial pending = 0;

    task automatic report_mismatch(string what, logic signed [63:0] got,
                                   logic signed [63:0] want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        err_count = err_count + 1;
    endtask

    // Region one goes on while H^2 * x < W^2 * y
    function automatic logic in_region_one();
        logic [63:0] h2, w2;
        h2 = 64'(dia_h) * 64'(dia_h);
        w2 = 64'(dia_w) * 64'(dia_w);
        return (h2 * 64'(walk_x)) < (w2 * 64'(walk_y));
    endfunction

    function automatic span_beat_t make_span(int sx, int sy, int sw, int sh);
        span_beat_t b;
        b.x     = sx[COORD_BITS:0];
        b.y     = sy[COORD_BITS:0];
        b.w     = sw[SIZE_BITS:0];
        b.h     = sh[SIZE_BITS:0];
        b.color = tag;
        b.vld   = 1'b1;
        b.last  = 1'b0;
        b.fin   = 1'b0;
        return b;
    endfunction

    // Latch a new ellipse and pick its starting region
    task automatic latch_ellipse();
        org_x  = int'(center_x);
        org_y  = int'(center_y);
        dia_w  = ellipse_width;
        dia_h  = ellipse_height;
        tag    = fill_color;
        walk_x = 0;
        walk_y = int'(dia_h >> 1);
        last_x = 1;
        last_y = walk_y;
        if (in_region_one())
            walk_stage = STG_ONE;
        else
        begin
            last_x = walk_x;
            last_y = walk_y;
            walk_stage = (walk_y != 0) ? STG_TWO : STG_DONE;
        end
    endtask

    // Run one loop iteration and queue the spans it should emit
    task automatic predict_spans();
        span_beat_t   batch[$];
        span_beat_t   b;
        logic [63:0]  h2, w2, tx, ty, txsq, tysq;
        logic [127:0] whole, point;
        int           d;
        logic         fin;
        h2    = 64'(dia_h) * 64'(dia_h);
        w2    = 64'(dia_w) * 64'(dia_w);
        whole = {64'd0, w2} * {64'd0, h2};
        if (walk_stage == STG_ONE)
        begin
            walk_x = walk_x + 1;
            tx    = 64'(walk_x) << 1;
            ty    = (64'(walk_y) << 1) - 64'd1;
            txsq  = tx * tx;
            tysq  = ty * ty;
            point = {64'd0, h2} * {64'd0, txsq} + {64'd0, w2} * {64'd0, tysq};
            if (point >= whole)
                walk_y = walk_y - 1;
            // single-pixel spans when the first column already drops a row
            if (walk_x == 1 && walk_y != last_y)
            begin
                batch.push_back(make_span(org_x, org_y + last_y - 1, 1, 1));
                batch.push_back(make_span(org_x, org_y - last_y, 1, 1));
            end
            if (walk_y != last_y)
            begin
                batch.push_back(make_span(org_x - walk_x + 1, org_y - last_y,
                                          2 * walk_x - 1, 1));
                batch.push_back(make_span(org_x - walk_x + 1, org_y + last_y,
                                          2 * walk_x - 1, 1));
                last_y = walk_y;
                last_x = walk_x;
            end
            // end of region one emits its closing pair
            if (!in_region_one())
            begin
                batch.push_back(make_span(org_x - walk_x, org_y - last_y, 2 * walk_x + 1, 1));
                batch.push_back(make_span(org_x - walk_x, org_y + last_y, 2 * walk_x + 1, 1));
                last_x = walk_x;
                last_y = walk_y;
                walk_stage = (walk_y != 0) ? STG_TWO : STG_DONE;
            end
        end
        else if (walk_stage == STG_TWO)
        begin
            walk_y = walk_y - 1;
            tx    = (64'(walk_x) << 1) + 64'd1;
            ty    = 64'(walk_y) << 1;
            txsq  = tx * tx;
            tysq  = ty * ty;
            point = {64'd0, h2} * {64'd0, txsq} + {64'd0, w2} * {64'd0, tysq};
            if (whole >= point)
                walk_x = walk_x + 1;
            if (walk_x != last_x)
            begin
                d = last_y - walk_y;
                batch.push_back(make_span(org_x - last_x, org_y - last_y, 2 * last_x + 1, d));
                batch.push_back(make_span(org_x - last_x, org_y + walk_y + 1,
                                          2 * last_x + 1, d));
                last_x = walk_x;
                last_y = walk_y;
            end
            // reaching the middle row closes the ellipse with a taller pair
            if (walk_y == 0)
            begin
                d = last_y - walk_y + 1;
                batch.push_back(make_span(org_x - last_x, org_y - last_y, 2 * walk_x + 1, d));
                batch.push_back(make_span(org_x - last_x, org_y + walk_y, 2 * walk_x + 1, d));
                walk_stage = STG_DONE;
            end
        end
        // an iteration with no span still gives one empty beat
        if (batch.size() == 0)
        begin
            b = make_span(0, 0, 0, 0);
            b.vld = 1'b0;
            batch.push_back(b);
        end
        fin = !(walk_stage == STG_ONE || walk_stage == STG_TWO);
        for (int k = 0; k < batch.size(); k++)
        begin
            b = batch[k];
            b.fin  = fin;
            b.last = (k == batch.size() - 1);
            due_spans.push_back(b);
        end
    endtask

    // Compare one output beat with the oldest due span
    task automatic check_beat();
        span_beat_t want;
        if (due_spans.size() == 0)
        begin
            report_mismatch("beat with no span due (span_x)", span_x, 0);
            return;
        end
        want = due_spans.pop_front();
        if (span_x !== want.x)
            report_mismatch("span_x", span_x, want.x);
        if (span_y !== want.y)
            report_mismatch("span_y", span_y, want.y);
        if (span_width !== want.w)
            report_mismatch("span_width", span_width, want.w);
        if (span_height !== want.h)
            report_mismatch("span_height", span_height, want.h);
        if (span_color !== want.color)
            report_mismatch("span_color", span_color, want.color);
        if (span_valid !== want.vld)
            report_mismatch("span_valid", span_valid, want.vld);
        if (last_of_step !== want.last)
            report_mismatch("last_of_step", last_of_step, want.last);
        if (finished !== want.fin)
            report_mismatch("finished", finished, want.fin);
    endtask

    // Check output beats before predicting, since a result never leaves on
    // the edge that accepts its input beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_stage    = STG_IDLE;
            walk_x        = 0;
            walk_y        = 0;
            last_x        = 0;
            last_y        = 0;
            org_x         = 0;
            org_y         = 0;
            dia_w         = '0;
            dia_h         = '0;
            tag           = '0;
            leftover_done = 1'b0;
            due_spans.delete();
            pending       = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_beat();
            if (in_valid && !in_stall)
            begin
                if (kind == KIND_LOAD)
                    latch_ellipse();
                else
                    predict_spans();
            end
            if (end_of_test && !leftover_done)
            begin
                leftover_done = 1'b1;
                if (due_spans.size() != 0)
                    report_mismatch("spans never delivered (count)", due_spans.size(), 0);
            end
            pending = due_spans.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the midpoint ellipse span generator.
// ----------------------------------------------------------------------------
// Drives load and step beats: a short directed part on the size and centre
// extremes, degenerate ellipses and idle steps, then random ellipses, mostly
// walked to the end, some cut short by a reload and some stray steps. Both
// sides stall at random in the first two of three phases and not in the last.
// The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
    import mesf_pkg::*;

    localparam int   SIZE_BITS    = 10;
    localparam int   COORD_BITS   = 16;
    localparam logic KIND_STEP    = ~KIND_LOAD;
    localparam int   RAND_ITEMS   = 460;
    localparam int   WALK_CAP     = 1500;
    localparam int   DRAIN_CYCLES = 40;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         kind = KIND_LOAD;
    logic signed [COORD_BITS-1:0] center_x = '0;
    logic signed [COORD_BITS-1:0] center_y = '0;
    logic        [SIZE_BITS-1:0]  ellipse_width = '0;
    logic        [SIZE_BITS-1:0]  ellipse_height = '0;
    logic        [31:0]           fill_color = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [COORD_BITS:0]   span_x;
    logic signed [COORD_BITS:0]   span_y;
    logic        [SIZE_BITS:0]    span_width;
    logic        [SIZE_BITS:0]    span_height;
    logic        [31:0]           span_color;
    logic                         span_valid;
    logic                         last_of_step;
    logic                         finished;
    logic                         end_of_test = 1'b0;
    int                           err_count;
    int                           pending;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic in_fire = 1'b0;
    int   items_sent = 0;
    int   steps_sent = 0;
    int   steps_done = 0;
    int   fin_mark = 0;

    midpoint_ellipse_span_fill #(
        .SIZE_BITS  (SIZE_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .center_x       (center_x),
        .center_y       (center_y),
        .ellipse_width  (ellipse_width),
        .ellipse_height (ellipse_height),
        .fill_color     (fill_color),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .span_x         (span_x),
        .span_y         (span_y),
        .span_width     (span_width),
        .span_height    (span_height),
        .span_color     (span_color),
        .span_valid     (span_valid),
        .last_of_step   (last_of_step),
        .finished       (finished)
    );

    mesf_span_checker #(
        .SIZE_BITS  (SIZE_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .center_x       (center_x),
        .center_y       (center_y),
        .ellipse_width  (ellipse_width),
        .ellipse_height (ellipse_height),
        .fill_color     (fill_color),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .span_x         (span_x),
        .span_y         (span_y),
        .span_width     (span_width),
        .span_height    (span_height),
        .span_color     (span_color),
        .span_valid     (span_valid),
        .last_of_step   (last_of_step),
        .finished       (finished),
        .end_of_test    (end_of_test),
        .err_count      (err_count),
        .pending        (pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the output side at random
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Note input acceptance, and the index of the latest step that reported
    // the walk finished
    always @(posedge clk)
    begin
        in_fire <= in_valid && !in_stall;
        if (out_valid && !out_stall && last_of_step)
        begin
            steps_done <= steps_done + 1;
            if (finished)
                fin_mark <= steps_done + 1;
        end
    end

    // Give up long after the slowest correct run
    initial
    begin
        #(20_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic set_phase(int phase);
        case (phase)
            0:
            begin
                send_idle_pct = 21;
                recv_idle_pct = 63;
            end
            1:
            begin
                send_idle_pct = 63;
                recv_idle_pct = 21;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Present one beat after a random gap and hold it until accepted;
    // entered and left at a falling edge
    task automatic send_item(logic k, logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                             logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h,
                             logic [31:0] col);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        kind           <= k;
        center_x       <= cx;
        center_y       <= cy;
        ellipse_width  <= w;
        ellipse_height <= h;
        fill_color     <= col;
        in_valid       <= 1'b1;
        do
            @(negedge clk);
        while (!in_fire);
        items_sent = items_sent + 1;
        if (k == KIND_STEP)
            steps_sent = steps_sent + 1;
    endtask

    // Random centre coordinate
    function automatic logic [COORD_BITS-1:0] pick_coord();
        return COORD_BITS'($urandom);
    endfunction

    // Step beats carry random filler in the unused fields
    task automatic send_step();
        send_item(KIND_STEP, pick_coord(), pick_coord(), SIZE_BITS'($urandom),
                  SIZE_BITS'($urandom), $urandom);
    endtask

    // Load an ellipse, then walk it to the end or cut it short
    task automatic run_walk(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                            logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h,
                            logic [31:0] col, bit to_end, int nsteps);
        int first_step;
        int count;
        send_item(KIND_LOAD, cx, cy, w, h, col);
        first_step = steps_sent + 1;
        count = 0;
        if (to_end)
        begin
            while (fin_mark < first_step && count < WALK_CAP)
            begin
                send_step();
                count = count + 1;
            end
            nsteps = $urandom_range(2);
        end
        repeat (nsteps)
            send_step();
    endtask

    // Mostly small sizes keep walks short; a few reach the full range
    function automatic logic [SIZE_BITS-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return SIZE_BITS'($urandom_range(20));
        else if (r < 93)
            return SIZE_BITS'($urandom_range(80));
        else if (r < 97)
            return SIZE_BITS'($urandom_range(300));
        else
            return SIZE_BITS'($urandom);
    endfunction

    initial
    begin
        int                   rand_start;
        int                   mode;
        logic [SIZE_BITS-1:0] w, h;

        set_phase(0);
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: idle step, empty and one-row ellipses, extreme centres
        send_step();
        run_walk(16'h7fff, 16'h8000, 10'd0, 10'd0, 32'hffff_ffff, 1'b0, 2);
        run_walk(16'h8000, 16'h7fff, 10'd1023, 10'd1, 32'h0000_0000, 1'b0, 1);
        run_walk(16'h0000, 16'h0000, 10'd1023, 10'd1023, 32'ha5a5_5a5a, 1'b0, 4);
        // zero width stays in region two; tall and wide shapes hit the
        // single-pixel and closing spans
        run_walk(pick_coord(), pick_coord(), 10'd0, 10'd6, $urandom, 1'b1, 0);
        run_walk(pick_coord(), pick_coord(), 10'd3, 10'd9, $urandom, 1'b1, 0);
        run_walk(pick_coord(), pick_coord(), 10'd12, 10'd4, $urandom, 1'b1, 0);

        // Random ellipses over three stall phases
        rand_start = items_sent;
        while (items_sent - rand_start < RAND_ITEMS)
        begin
            set_phase((items_sent - rand_start) * 3 / RAND_ITEMS);
            w = pick_size();
            h = pick_size();
            mode = $urandom_range(99);
            if (w > 300 || h > 300)
                run_walk(pick_coord(), pick_coord(), w, h, $urandom, 1'b0, $urandom_range(20));
            else if (mode < 12)
                run_walk(pick_coord(), pick_coord(), w, h, $urandom, 1'b0, $urandom_range(6));
            else if (mode < 17)
                repeat ($urandom_range(1, 2))
                    send_step();
            else
                run_walk(pick_coord(), pick_coord(), w, h, $urandom, 1'b1, 0);
        end
        in_valid <= 1'b0;

        // Drain what is due, then let late beats show up
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        end_of_test <= 1'b1;
        @(negedge clk);
        @(negedge clk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
